FILE: src/rme_pkg.sv
package rme_pkg;

    // default sizes of the machine state
    localparam int DEF_REG_WIDTH = 32;
    localparam int DEF_REG_COUNT = 16;
    localparam int DEF_MEM_DEPTH = 256;

    // item field widths
    localparam int OP_W   = 5;
    localparam int IDX_W  = 4;
    localparam int IMM_W  = 32;
    localparam int BYTE_W = 8;

    // stream widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    // register file read ports
    localparam int RD_PORTS = 3;
    localparam int PORT_A   = 0;
    localparam int PORT_B   = 1;
    localparam int PORT_D   = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_READ  = OP_W'(0);
    localparam logic [OP_W-1:0] OP_WRITE = OP_W'(1);
    localparam logic [OP_W-1:0] OP_SET   = OP_W'(2);
    localparam logic [OP_W-1:0] OP_ADD   = OP_W'(3);
    localparam logic [OP_W-1:0] OP_ADDI  = OP_W'(4);
    localparam logic [OP_W-1:0] OP_SUB   = OP_W'(5);
    localparam logic [OP_W-1:0] OP_SUBI  = OP_W'(6);
    localparam logic [OP_W-1:0] OP_SHL   = OP_W'(7);
    localparam logic [OP_W-1:0] OP_SHR   = OP_W'(8);
    localparam logic [OP_W-1:0] OP_ANDI  = OP_W'(9);
    localparam logic [OP_W-1:0] OP_ORI   = OP_W'(10);
    localparam logic [OP_W-1:0] OP_XORI  = OP_W'(11);
    localparam logic [OP_W-1:0] OP_AND   = OP_W'(12);
    localparam logic [OP_W-1:0] OP_OR    = OP_W'(13);
    localparam logic [OP_W-1:0] OP_XOR   = OP_W'(14);
    localparam logic [OP_W-1:0] OP_STR   = OP_W'(15);
    localparam logic [OP_W-1:0] OP_LDR   = OP_W'(16);
    localparam logic [OP_W-1:0] OP_ST    = OP_W'(17);
    localparam logic [OP_W-1:0] OP_LD    = OP_W'(18);
    localparam logic [OP_W-1:0] OP_JMP   = OP_W'(19);
    localparam logic [OP_W-1:0] OP_JZ    = OP_W'(20);
    localparam logic [OP_W-1:0] OP_JNZ   = OP_W'(21);
    localparam logic [OP_W-1:0] OP_HLT   = OP_W'(22);

    // register writes still owed by an item in the result stage
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic       halted;
        logic       jump_taken;
        logic       out_valid;
        logic [1:0] pend;
        logic       use_mem;
        logic       mem_we;
        logic       mem_re;
    } rme_ctl_t;

endpackage

FILE: src/rme_ram.sv
module rme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

FILE: src/rme_regfile.sv
module rme_regfile #(
    parameter int REG_WIDTH = rme_pkg::DEF_REG_WIDTH,
    parameter int REG_COUNT = rme_pkg::DEF_REG_COUNT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(REG_COUNT)-1:0] rd_addr [rme_pkg::RD_PORTS],
    input  logic                         we,
    input  logic [$clog2(REG_COUNT)-1:0] waddr,
    input  logic [REG_WIDTH-1:0]         wdata,
    output logic [REG_WIDTH-1:0]         opnd [rme_pkg::RD_PORTS]
);

    import rme_pkg::*;

    localparam int RIDX_W = $clog2(REG_COUNT);

    logic [REG_COUNT-1:0] vld_reg;
    logic [RIDX_W-1:0]    addr_reg     [RD_PORTS];
    logic                 vld_cap_reg  [RD_PORTS];
    logic                 ovr_hit_reg  [RD_PORTS];
    logic [REG_WIDTH-1:0] ovr_data_reg [RD_PORTS];
    logic [REG_WIDTH-1:0] q            [RD_PORTS];

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    for (genvar p = 0; p < RD_PORTS; p++) begin : g_port
        rme_ram #(
            .WIDTH (REG_WIDTH),
            .DEPTH (REG_COUNT)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .re    (rd_en),
            .raddr (rd_addr[p]),
            .rdata (q[p])
        );

        // track writes that land after the ram was read
        always_ff @(posedge aclk) begin
            if (rd_en) begin
                addr_reg[p]     <= rd_addr[p];
                vld_cap_reg[p]  <= vld_reg[rd_addr[p]];
                ovr_hit_reg[p]  <= we && (waddr == rd_addr[p]);
                ovr_data_reg[p] <= wdata;
            end else if (we && (waddr == addr_reg[p])) begin
                ovr_hit_reg[p]  <= 1'b1;
                ovr_data_reg[p] <= wdata;
            end
        end

        always_comb begin
            if (we && (waddr == addr_reg[p])) begin
                opnd[p] = wdata;
            end else if (ovr_hit_reg[p]) begin
                opnd[p] = ovr_data_reg[p];
            end else if (vld_cap_reg[p]) begin
                opnd[p] = q[p];
            end else begin
                opnd[p] = '0;
            end
        end
    end

endmodule

FILE: src/rme_alu.sv
module rme_alu #(
    parameter int REG_WIDTH = rme_pkg::DEF_REG_WIDTH,
    parameter int REG_COUNT = rme_pkg::DEF_REG_COUNT,
    parameter int MEM_DEPTH = rme_pkg::DEF_MEM_DEPTH
) (
    input  logic [rme_pkg::OP_W-1:0]     op,
    input  logic [$clog2(REG_COUNT)-1:0] d_idx,
    input  logic [$clog2(REG_COUNT)-1:0] a_idx,
    input  logic [$clog2(REG_COUNT)-1:0] ld_idx,
    input  logic [rme_pkg::IMM_W-1:0]    imm,
    input  logic [rme_pkg::BYTE_W-1:0]   in_byte,
    input  logic                         in_avail,
    input  logic [REG_WIDTH-1:0]         ra,
    input  logic [REG_WIDTH-1:0]         rb,
    input  logic [REG_WIDTH-1:0]         rd,
    output rme_pkg::rme_ctl_t            ctl,
    output logic [$clog2(REG_COUNT)-1:0] waddr,
    output logic [$clog2(REG_COUNT)-1:0] xaddr,
    output logic                         xbit,
    output logic [REG_WIDTH-1:0]         wres,
    output logic [rme_pkg::IMM_W-1:0]    jtarget,
    output logic [rme_pkg::BYTE_W-1:0]   obyte,
    output logic [$clog2(MEM_DEPTH)-1:0] mem_addr,
    output logic [rme_pkg::BYTE_W-1:0]   mem_wdata
);

    import rme_pkg::*;

    localparam int SH_W = $clog2(REG_WIDTH);

    logic [REG_WIDTH-1:0] immw;
    logic                 big_sh;
    logic [SH_W-1:0]      sh;
    logic                 rd_zero;

    assign immw     = REG_WIDTH'(imm);
    assign big_sh   = imm >= IMM_W'(REG_WIDTH);
    assign sh       = imm[SH_W-1:0];
    assign rd_zero  = (rd == '0);
    assign mem_addr = ra[$clog2(MEM_DEPTH)-1:0];
    assign xaddr    = a_idx;
    assign xbit     = in_avail;

    // decoder: writes, memory access, result flags
    always_comb begin
        ctl       = '0;
        waddr     = d_idx;
        jtarget   = '0;
        obyte     = '0;
        mem_wdata = rd[BYTE_W-1:0];
        unique case (op) inside
            OP_READ: begin
                ctl.pend = PEND_TWO;
            end
            OP_WRITE: begin
                ctl.pend      = PEND_ONE;
                ctl.out_valid = 1'b1;
                obyte         = rd[BYTE_W-1:0];
                waddr         = a_idx;
            end
            OP_SET, OP_ADD, OP_ADDI, OP_SUB, OP_SUBI, OP_SHL, OP_SHR,
            OP_ANDI, OP_ORI, OP_XORI, OP_AND, OP_OR, OP_XOR: begin
                ctl.pend = PEND_ONE;
            end
            OP_STR: begin
                ctl.mem_we = 1'b1;
            end
            OP_LDR: begin
                ctl.pend    = PEND_ONE;
                ctl.use_mem = 1'b1;
                ctl.mem_re  = 1'b1;
            end
            OP_ST: begin
                ctl.mem_we = 1'b1;
                mem_wdata  = imm[BYTE_W-1:0];
            end
            OP_LD: begin
                ctl.pend    = PEND_ONE;
                ctl.use_mem = 1'b1;
                ctl.mem_re  = 1'b1;
                waddr       = ld_idx;
            end
            OP_JMP: begin
                ctl.jump_taken = 1'b1;
                jtarget        = imm;
            end
            OP_JZ: begin
                if (rd_zero) begin
                    ctl.jump_taken = 1'b1;
                    jtarget        = imm;
                end
            end
            OP_JNZ: begin
                if (!rd_zero) begin
                    ctl.jump_taken = 1'b1;
                    jtarget        = imm;
                end
            end
            OP_HLT: begin
                ctl.halted = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // register result
    always_comb begin
        case (op)
            OP_READ:  wres = in_avail ? REG_WIDTH'(in_byte) : '0;
            OP_WRITE: wres = REG_WIDTH'(1'b1);
            OP_SET:   wres = immw;
            OP_ADD:   wres = ra + rb;
            OP_ADDI:  wres = ra + immw;
            OP_SUB:   wres = ra - rb;
            OP_SUBI:  wres = ra - immw;
            OP_SHL:   wres = big_sh ? '0 : (ra << sh);
            OP_SHR:   wres = big_sh ? '0 : (ra >> sh);
            OP_ANDI:  wres = ra & immw;
            OP_ORI:   wres = ra | immw;
            OP_XORI:  wres = ra ^ immw;
            OP_AND:   wres = ra & rb;
            OP_OR:    wres = ra | rb;
            OP_XOR:   wres = ra ^ rb;
            default:  wres = '0;
        endcase
    end

endmodule

FILE: src/register_machine_execute_unit_core.sv
// pipeline: an accepted item passes the execute stage and then the result stage, where its result is offered
// throughput: one item per cycle, unless m_axis_tready is low or a read holds the result stage
// while it writes two registers through the single register file write port
// reset: synchronous, active low; empties both pipeline stages and clears the valid bits
// of the register file and the data memory so every entry reads as zero, no clearing pass
module register_machine_execute_unit_core #(
    parameter int REG_WIDTH = rme_pkg::DEF_REG_WIDTH,
    parameter int REG_COUNT = rme_pkg::DEF_REG_COUNT,
    parameter int MEM_DEPTH = rme_pkg::DEF_MEM_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // instruction items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // operation, dest_reg, src_reg_a, src_reg_b, immediate, in_byte, zero pad
    input  logic [rme_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // in_available
    input  logic                          s_axis_tuser,
    // result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // jump_target, out_byte
    output logic [rme_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // halted, jump_taken, out_valid
    output logic [rme_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    import rme_pkg::*;

    localparam int RIDX_W = $clog2(REG_COUNT);
    localparam int MEM_AW = $clog2(MEM_DEPTH);

    // input field offsets
    localparam int D_LSB   = OP_W;
    localparam int A_LSB   = D_LSB + IDX_W;
    localparam int B_LSB   = A_LSB + IDX_W;
    localparam int IMM_LSB = B_LSB + IDX_W;
    localparam int IB_LSB  = IMM_LSB + IMM_W;

    // result flag positions in tuser
    localparam int U_HALT = 0;
    localparam int U_JUMP = 1;
    localparam int U_OUT  = 2;

    // register indices wrap at the register count
    function automatic logic [RIDX_W-1:0] reg_index(input logic [IDX_W-1:0] v);
        logic [RIDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << IDX_W); i++) begin
            if (v == IDX_W'(i)) begin
                r = RIDX_W'(i % REG_COUNT);
            end
        end
        return r;
    endfunction

    // handshake and pipeline control
    logic s_acc;
    logic e_adv;
    logic w_adv;
    logic w_last;

    // execute stage: the accepted item, register operands arrive from the ram outputs
    logic              e_vld_reg;
    logic [OP_W-1:0]   e_op_reg;
    logic [RIDX_W-1:0] e_d_reg;
    logic [RIDX_W-1:0] e_a_reg;
    logic [RIDX_W-1:0] e_ld_reg;
    logic [IMM_W-1:0]  e_imm_reg;
    logic [BYTE_W-1:0] e_ib_reg;
    logic              e_avail_reg;

    logic [RIDX_W-1:0]    rd_addr [RD_PORTS];
    logic [REG_WIDTH-1:0] opnd    [RD_PORTS];

    // execute outputs
    rme_ctl_t          x_ctl;
    logic [RIDX_W-1:0] x_waddr;
    logic [RIDX_W-1:0] x_xaddr;
    logic              x_xbit;
    logic [REG_WIDTH-1:0] x_wres;
    logic [IMM_W-1:0]  x_jtarget;
    logic [BYTE_W-1:0] x_obyte;
    logic [MEM_AW-1:0] x_mem_addr;
    logic [BYTE_W-1:0] x_mem_wdata;

    // result stage: doubles as the output register and does the register writeback
    logic                 w_vld_reg;
    rme_ctl_t             w_ctl_reg;
    logic [RIDX_W-1:0]    w_waddr_reg;
    logic [RIDX_W-1:0]    w_xaddr_reg;
    logic                 w_xbit_reg;
    logic [REG_WIDTH-1:0] w_res_reg;
    logic [IMM_W-1:0]     w_jtarget_reg;
    logic [BYTE_W-1:0]    w_obyte_reg;
    logic                 w_mvld_reg;

    // register file write port
    logic                 rf_we;
    logic [RIDX_W-1:0]    rf_waddr;
    logic [REG_WIDTH-1:0] rf_wdata;

    // data memory
    logic [MEM_DEPTH-1:0] mvld_reg;
    logic [BYTE_W-1:0]    dmem_q;
    logic [BYTE_W-1:0]    mem_byte;
    logic                 dmem_we;
    logic                 dmem_re;

    // a result leaves once its last register write is under way; read owes two writes
    assign w_last        = (w_ctl_reg.pend != PEND_TWO);
    assign m_axis_tvalid = w_vld_reg && w_last;
    assign w_adv         = !w_vld_reg || (w_last && m_axis_tready);
    assign e_adv         = e_vld_reg && w_adv;
    assign s_axis_tready = !e_vld_reg || w_adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // register reads are issued straight from the incoming item
    assign rd_addr[PORT_A] = reg_index(s_axis_tdata[A_LSB +: IDX_W]);
    assign rd_addr[PORT_B] = reg_index(s_axis_tdata[B_LSB +: IDX_W]);
    assign rd_addr[PORT_D] = reg_index(s_axis_tdata[D_LSB +: IDX_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (s_acc) begin
            e_vld_reg <= 1'b1;
        end else if (e_adv) begin
            e_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            e_op_reg    <= s_axis_tdata[OP_W-1:0];
            e_d_reg     <= rd_addr[PORT_D];
            e_a_reg     <= rd_addr[PORT_A];
            e_ld_reg    <= reg_index(s_axis_tdata[IMM_LSB +: IDX_W]);
            e_imm_reg   <= s_axis_tdata[IMM_LSB +: IMM_W];
            e_ib_reg    <= s_axis_tdata[IB_LSB +: BYTE_W];
            e_avail_reg <= s_axis_tuser;
        end
    end

    rme_regfile #(
        .REG_WIDTH (REG_WIDTH),
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_acc),
        .rd_addr (rd_addr),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .opnd    (opnd)
    );

    rme_alu #(
        .REG_WIDTH (REG_WIDTH),
        .REG_COUNT (REG_COUNT),
        .MEM_DEPTH (MEM_DEPTH)
    ) u_alu (
        .op        (e_op_reg),
        .d_idx     (e_d_reg),
        .a_idx     (e_a_reg),
        .ld_idx    (e_ld_reg),
        .imm       (e_imm_reg),
        .in_byte   (e_ib_reg),
        .in_avail  (e_avail_reg),
        .ra        (opnd[PORT_A]),
        .rb        (opnd[PORT_B]),
        .rd        (opnd[PORT_D]),
        .ctl       (x_ctl),
        .waddr     (x_waddr),
        .xaddr     (x_xaddr),
        .xbit      (x_xbit),
        .wres      (x_wres),
        .jtarget   (x_jtarget),
        .obyte     (x_obyte),
        .mem_addr  (x_mem_addr),
        .mem_wdata (x_mem_wdata)
    );

    // memory is touched as the item leaves execute, so accesses stay in program order
    assign dmem_we = e_adv && x_ctl.mem_we;
    assign dmem_re = e_adv && x_ctl.mem_re;

    rme_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_dmem (
        .aclk  (aclk),
        .we    (dmem_we),
        .waddr (x_mem_addr),
        .wdata (x_mem_wdata),
        .re    (dmem_re),
        .raddr (x_mem_addr),
        .rdata (dmem_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvld_reg <= '0;
        end else if (dmem_we) begin
            mvld_reg[x_mem_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_vld_reg <= 1'b0;
        end else if (w_adv) begin
            w_vld_reg <= e_vld_reg;
        end
    end

    // payload of the result stage; the pending count steps down with each write
    always_ff @(posedge aclk) begin
        if (w_adv) begin
            w_ctl_reg     <= x_ctl;
            w_waddr_reg   <= x_waddr;
            w_xaddr_reg   <= x_xaddr;
            w_xbit_reg    <= x_xbit;
            w_res_reg     <= x_wres;
            w_jtarget_reg <= x_jtarget;
            w_obyte_reg   <= x_obyte;
            w_mvld_reg    <= mvld_reg[x_mem_addr];
        end else if (rf_we) begin
            w_ctl_reg.pend <= w_ctl_reg.pend - 2'd1;
        end
    end

    // writeback: the status flag of read goes first, then the main destination
    assign mem_byte = w_mvld_reg ? dmem_q : '0;
    assign rf_we    = w_vld_reg && (w_ctl_reg.pend != PEND_NONE);

    always_comb begin
        if (w_ctl_reg.pend == PEND_TWO) begin
            rf_waddr = w_xaddr_reg;
            rf_wdata = REG_WIDTH'(w_xbit_reg);
        end else begin
            rf_waddr = w_waddr_reg;
            rf_wdata = w_ctl_reg.use_mem ? REG_WIDTH'(mem_byte) : w_res_reg;
        end
    end

    assign m_axis_tdata         = {w_obyte_reg, w_jtarget_reg};
    assign m_axis_tuser[U_HALT] = w_ctl_reg.halted;
    assign m_axis_tuser[U_JUMP] = w_ctl_reg.jump_taken;
    assign m_axis_tuser[U_OUT]  = w_ctl_reg.out_valid;

    // read always stays in the result stage for its second write after the flag write
    a_read_two_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (w_vld_reg && (w_ctl_reg.pend == PEND_TWO)) |=>
        (w_vld_reg && (w_ctl_reg.pend == PEND_ONE)))
        else $error("read item left the result stage early");

    // an item held in execute is not dropped
    a_exec_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_vld_reg && !w_adv) |=> e_vld_reg)
        else $error("stalled item lost from execute");

    // nothing offered straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // a target is only carried with a taken jump
    a_target_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[U_JUMP]) |-> (m_axis_tdata[IMM_W-1:0] == '0))
        else $error("jump target without a taken jump");

endmodule

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rme_pkg::*;

    // opcodes past the last defined one: no state change, all-zero result
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_W'(23);
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = OP_W'(31);

    localparam int REG_W        = DEF_REG_WIDTH;
    localparam int RANDOM_ITEMS = 1800;
    localparam int TAIL_ITEMS   = 200;   // last stretch runs without any idling
    localparam int SEGMENT      = 150;   // idling rates are re-drawn this often
    localparam int DRAIN_CYCLES = 8;     // read holds the result stage longest, so this is ample
    localparam int PRINT_CAP    = 40;

    // one decoded instruction
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [IDX_W-1:0]  rd;
        logic [IDX_W-1:0]  ra;
        logic [IDX_W-1:0]  rb;
        logic [IMM_W-1:0]  imm;
        logic [BYTE_W-1:0] in_byte;
        logic              avail;
    } instr_t;

    // what one instruction reports
    typedef struct packed {
        logic              halted;
        logic              jump_taken;
        logic [IMM_W-1:0]  jump_target;
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
    } exec_result_t;

    typedef struct {
        instr_t       ins;
        bit           known;   // expected result written out by hand
        exec_result_t want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // own copy of the machine state
    logic [REG_W-1:0]  model_regs [DEF_REG_COUNT];
    logic [BYTE_W-1:0] model_mem  [DEF_MEM_DEPTH];

    exec_result_t pending_results [$];
    dir_row_t     dir_rows [$];

    int  mismatches   = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  jumps_seen   = 0;
    int  halts_seen   = 0;
    int  bytes_seen   = 0;
    int  send_idle_pct  = 25;
    int  stall_pct      = 25;
    bit  tail_phase     = 1'b0;

    exec_result_t observed;
    exec_result_t oldest;

    register_machine_execute_unit_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic instr_t make_instr(logic [OP_W-1:0] op, int d, int a, int b,
                                          logic [IMM_W-1:0] imm, logic [BYTE_W-1:0] bt,
                                          logic av);
        instr_t it;
        it.opcode  = op;
        it.rd      = IDX_W'(d);
        it.ra      = IDX_W'(a);
        it.rb      = IDX_W'(b);
        it.imm     = imm;
        it.in_byte = bt;
        it.avail   = av;
        return it;
    endfunction

    function automatic exec_result_t make_result(logic h, logic jt, logic [IMM_W-1:0] tgt,
                                                 logic ov, logic [BYTE_W-1:0] ob);
        exec_result_t r;
        r.halted      = h;
        r.jump_taken  = jt;
        r.jump_target = tgt;
        r.out_valid   = ov;
        r.out_byte    = ob;
        return r;
    endfunction

    // executes one instruction on the local state and returns its report
    function automatic exec_result_t execute_instr(instr_t it);
        exec_result_t r;
        logic [REG_W-1:0] va;
        logic [REG_W-1:0] vb;
        logic [REG_W-1:0] vd;
        logic [REG_W-1:0] wb;
        logic             wr;
        r  = '0;
        wr = 1'b0;
        wb = '0;
        va = model_regs[it.ra];
        vb = model_regs[it.rb];
        vd = model_regs[it.rd];
        case (it.opcode)
            OP_READ: begin
                // flag first, so the byte wins when both indexes match
                model_regs[it.ra] = REG_W'(it.avail);
                model_regs[it.rd] = it.avail ? REG_W'(it.in_byte) : '0;
            end
            OP_WRITE: begin
                r.out_valid = 1'b1;
                r.out_byte  = vd[BYTE_W-1:0];
                model_regs[it.ra] = REG_W'(1);
            end
            OP_SET:  begin wb = it.imm;   wr = 1'b1; end
            OP_ADD:  begin wb = va + vb;  wr = 1'b1; end
            OP_ADDI: begin wb = va + it.imm; wr = 1'b1; end
            OP_SUB:  begin wb = va - vb;  wr = 1'b1; end
            OP_SUBI: begin wb = va - it.imm; wr = 1'b1; end
            OP_SHL: begin
                wb = (it.imm >= REG_W) ? '0 : va << it.imm;
                wr = 1'b1;
            end
            OP_SHR: begin
                wb = (it.imm >= REG_W) ? '0 : va >> it.imm;
                wr = 1'b1;
            end
            OP_ANDI: begin wb = va & it.imm; wr = 1'b1; end
            OP_ORI:  begin wb = va | it.imm; wr = 1'b1; end
            OP_XORI: begin wb = va ^ it.imm; wr = 1'b1; end
            OP_AND:  begin wb = va & vb;  wr = 1'b1; end
            OP_OR:   begin wb = va | vb;  wr = 1'b1; end
            OP_XOR:  begin wb = va ^ vb;  wr = 1'b1; end
            OP_STR:  model_mem[va[7:0]] = vd[BYTE_W-1:0];
            OP_LDR:  begin wb = REG_W'(model_mem[va[7:0]]); wr = 1'b1; end
            OP_ST:   model_mem[va[7:0]] = it.imm[BYTE_W-1:0];
            OP_LD:   model_regs[it.imm[IDX_W-1:0]] = REG_W'(model_mem[va[7:0]]);
            OP_JMP: begin
                r.jump_taken  = 1'b1;
                r.jump_target = it.imm;
            end
            OP_JZ: begin
                if (vd == '0) begin
                    r.jump_taken  = 1'b1;
                    r.jump_target = it.imm;
                end
            end
            OP_JNZ: begin
                if (vd != '0) begin
                    r.jump_taken  = 1'b1;
                    r.jump_target = it.imm;
                end
            end
            OP_HLT: r.halted = 1'b1;
            default: ;
        endcase
        if (wr)
            model_regs[it.rd] = wb;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [IMM_W-1:0] got, logic [IMM_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] result %0d: %s got %0h, want %0h", $realtime, results_seen, what,
                     got, want);
    endtask

    // offers one item and holds it until the block takes it
    task automatic issue_instr(instr_t it, bit known, exec_result_t want);
        exec_result_t predicted;
        s_axis_tdata  <= {7'b0, it.in_byte, it.imm, it.rb, it.ra, it.rd, it.opcode};
        s_axis_tuser  <= it.avail;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        // accepted at this edge: step the local state in acceptance order
        predicted = execute_instr(it);
        pending_results.push_back(known ? want : predicted);
        items_sent++;
    endtask

    // random gap on the sending side
    task automatic maybe_idle_sender();
        if (!tail_phase && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge aclk);
        end
    endtask

    // sender holds off until every outstanding result has drained
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // result side back-pressure in random bursts
    initial begin
        @(posedge aclk);
        forever begin
            if (!tail_phase && $urandom_range(99, 0) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(5, 1)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            observed.halted      = m_axis_tuser[0];
            observed.jump_taken  = m_axis_tuser[1];
            observed.out_valid   = m_axis_tuser[2];
            observed.jump_target = m_axis_tdata[31:0];
            observed.out_byte    = m_axis_tdata[39:32];
            results_seen++;
            if (observed.jump_taken === 1'b1) jumps_seen++;
            if (observed.halted === 1'b1)     halts_seen++;
            if (observed.out_valid === 1'b1)  bytes_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing pending", IMM_W'(observed.jump_target), '0);
            end else begin
                oldest = pending_results.pop_front();
                if (observed.halted !== oldest.halted)
                    flag_mismatch("halted", IMM_W'(observed.halted), IMM_W'(oldest.halted));
                if (observed.jump_taken !== oldest.jump_taken)
                    flag_mismatch("jump_taken", IMM_W'(observed.jump_taken),
                                  IMM_W'(oldest.jump_taken));
                if (observed.jump_target !== oldest.jump_target)
                    flag_mismatch("jump_target", observed.jump_target, oldest.jump_target);
                if (observed.out_valid !== oldest.out_valid)
                    flag_mismatch("out_valid", IMM_W'(observed.out_valid),
                                  IMM_W'(oldest.out_valid));
                if (observed.out_byte !== oldest.out_byte)
                    flag_mismatch("out_byte", IMM_W'(observed.out_byte),
                                  IMM_W'(oldest.out_byte));
            end
        end
    end

    initial begin : stimulus
        instr_t       it;
        exec_result_t none;
        int           n_directed;
        int           hi_idx;

        none = '0;
        foreach (model_regs[i]) model_regs[i] = '0;
        foreach (model_mem[i])  model_mem[i]  = '0;

        // directed rows; known ones rely on earlier rows and the cleared state after reset
        // taken branch on a cleared register, widest target
        dir_rows.push_back('{make_instr(OP_JZ, 0, 0, 0, 32'hFFFF_FFFF, 8'h00, 1'b0), 1'b1,
                             make_result(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 8'h00)});
        dir_rows.push_back('{make_instr(OP_HLT, 0, 0, 0, 32'h0, 8'h00, 1'b0), 1'b1,
                             make_result(1'b1, 1'b0, 32'h0, 1'b0, 8'h00)});
        // undefined opcode with every field at its top value
        dir_rows.push_back('{make_instr(OP_UNUSED_LAST, 15, 15, 15, 32'hFFFF_FFFF, 8'hFF, 1'b1),
                             1'b1, none});
        dir_rows.push_back('{make_instr(OP_UNUSED_FIRST, 15, 0, 15, 32'h0, 8'h00, 1'b0),
                             1'b1, none});
        // byte out of a cleared register, status lands in r7
        dir_rows.push_back('{make_instr(OP_WRITE, 3, 7, 0, 32'h0, 8'h00, 1'b0), 1'b1,
                             make_result(1'b0, 1'b0, 32'h0, 1'b1, 8'h00)});
        dir_rows.push_back('{make_instr(OP_JMP, 0, 0, 0, 32'h0, 8'h00, 1'b0), 1'b1,
                             make_result(1'b0, 1'b1, 32'h0, 1'b0, 8'h00)});
        dir_rows.push_back('{make_instr(OP_JNZ, 7, 0, 0, 32'h8000_0000, 8'h00, 1'b0), 1'b1,
                             make_result(1'b0, 1'b1, 32'h8000_0000, 1'b0, 8'h00)});
        // input reads: plain, with matching indexes, and with nothing available
        dir_rows.push_back('{make_instr(OP_READ, 1, 2, 0, 32'h0, 8'hFF, 1'b1), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_READ, 4, 4, 0, 32'h0, 8'hA5, 1'b1), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_READ, 5, 6, 0, 32'h0, 8'h3C, 1'b0), 1'b0, none});
        // output byte taken before the status overwrites the same register
        dir_rows.push_back('{make_instr(OP_WRITE, 4, 4, 0, 32'h0, 8'h00, 1'b0), 1'b0, none});
        // arithmetic with wrap-around at both ends
        dir_rows.push_back('{make_instr(OP_SET, 8, 0, 0, 32'hFFFF_FFFF, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_ADDI, 9, 8, 0, 32'h1, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_ADD, 10, 8, 8, 32'h0, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_SUB, 11, 9, 8, 32'h0, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_SUBI, 12, 9, 0, 32'hFFFF_FFFF, 8'h00, 1'b0), 1'b0,
                             none});
        // shifts at the top amount and one past it
        dir_rows.push_back('{make_instr(OP_SHL, 13, 8, 0, 32'd31, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_SHL, 14, 8, 0, 32'd32, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_SHR, 0, 8, 0, 32'd31, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_ANDI, 1, 8, 0, 32'h0F0F_0F0F, 8'h00, 1'b0), 1'b0,
                             none});
        dir_rows.push_back('{make_instr(OP_ORI, 2, 1, 0, 32'hF000_0000, 8'h00, 1'b0), 1'b0,
                             none});
        dir_rows.push_back('{make_instr(OP_XORI, 3, 2, 0, 32'hFFFF_FFFF, 8'h00, 1'b0), 1'b0,
                             none});
        dir_rows.push_back('{make_instr(OP_AND, 5, 8, 1, 32'h0, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_OR, 6, 3, 1, 32'h0, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_XOR, 7, 2, 13, 32'h0, 8'h00, 1'b0), 1'b0, none});
        // memory at the lowest and highest address
        dir_rows.push_back('{make_instr(OP_ST, 0, 9, 0, 32'h0000_ABCD, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_STR, 1, 8, 0, 32'h0, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_LDR, 10, 9, 0, 32'h0, 8'h00, 1'b0), 1'b0, none});
        // load whose destination comes from the immediate's low nibble
        dir_rows.push_back('{make_instr(OP_LD, 0, 8, 0, 32'hFFFF_FFF3, 8'h00, 1'b0), 1'b0, none});
        dir_rows.push_back('{make_instr(OP_WRITE, 3, 0, 0, 32'h0, 8'h00, 1'b0), 1'b0, none});
        n_directed = dir_rows.size();

        // reset applied once, at the start of the run
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k]) begin
            issue_instr(dir_rows[k].ins, dir_rows[k].known, dir_rows[k].want);
            maybe_idle_sender();
        end
        pause_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // idling rates change per segment, some segments have none
            if (n % SEGMENT == 0) begin
                case ($urandom_range(2, 0))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 20;
                    default: send_idle_pct = 50;
                endcase
                case ($urandom_range(2, 0))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    default: stall_pct = 50;
                endcase
            end
            if (n == RANDOM_ITEMS - TAIL_ITEMS)
                tail_phase = 1'b1;
            if (n == RANDOM_ITEMS / 2)
                pause_until_drained();

            // mostly defined opcodes, a few undefined ones
            if ($urandom_range(99, 0) < 4)
                it.opcode = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
            else
                it.opcode = OP_W'($urandom_range(OP_HLT, OP_READ));
            // half the time a narrow register window, so results feed each other
            hi_idx = ($urandom_range(1, 0) == 0) ? 3 : 15;
            it.rd = IDX_W'($urandom_range(hi_idx, 0));
            it.ra = IDX_W'($urandom_range(hi_idx, 0));
            it.rb = IDX_W'($urandom_range(hi_idx, 0));
            case ($urandom_range(3, 0))
                0: it.imm = $urandom;
                1: it.imm = $urandom_range(40, 0);
                2: it.imm = $urandom_range(255, 0);
                default: begin
                    case ($urandom_range(4, 0))
                        0: it.imm = 32'h0;
                        1: it.imm = 32'hFFFF_FFFF;
                        2: it.imm = 32'd32;
                        3: it.imm = 32'd31;
                        default: it.imm = 32'h8000_0000;
                    endcase
                end
            endcase
            it.in_byte = BYTE_W'($urandom);
            it.avail   = 1'($urandom_range(1, 0));
            issue_instr(it, 1'b0, none);
            maybe_idle_sender();
        end
        s_axis_tvalid <= 1'b0;

        // drain what is still in flight, then a few quiet cycles
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d instructions (%0d directed, %0d random), %0d results",
                 items_sent, n_directed, RANDOM_ITEMS, results_seen);
        $display("reports seen: %0d jumps, %0d halts, %0d bytes out; %0d mismatches",
                 jumps_seen, halts_seen, bytes_seen, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/rme_pkg.sv
src/rme_ram.sv
src/rme_regfile.sv
src/rme_alu.sv
src/register_machine_execute_unit_core.sv
sim/tb_top.sv
